>>> design/brcm_pkg.sv
package brcm_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int COLOR_W   = 8;
    localparam int RAMP_INT  = 8;
    localparam int REG_IDX_W = 2;
    localparam int QUOT_IN_W = 15;
    localparam int SCALE_CFG_W = 32;

    localparam logic [REG_IDX_W-1:0] REG_MIN_VALUE  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BAND_WIDTH = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BAND_SCALE = 2'd2;

    localparam logic [COLOR_W-1:0] LOW_END    = 8'd76;
    localparam logic [COLOR_W-1:0] CH_MAX     = 8'd255;
    localparam logic [COLOR_W-1:0] CH_ZERO    = 8'd0;
    localparam logic [COLOR_W-1:0] DIM_OFFSET = 8'd64;

    typedef enum logic [1:0] {
        BAND_BASE  = 2'd0,
        BAND_LOWER = 2'd1,
        BAND_UPPER = 2'd2,
        BAND_TOP   = 2'd3
    } band_t;

    // c*3/4 + 64
    function automatic logic [COLOR_W-1:0] dim(input logic [COLOR_W-1:0] c);
        logic [COLOR_W+1:0] c3;
        c3 = {2'b00, c} + {1'b0, c, 1'b0};
        return c3[COLOR_W+1:2] + DIM_OFFSET;
    endfunction

    // floor(x/255), exact for every 15-bit x
    function automatic logic [COLOR_W-1:0] div255(input logic [QUOT_IN_W-1:0] x);
        logic [15:0] s;
        s = 16'(x) + 16'(x >> 8) + 16'd1;
        return s[15:8];
    endfunction

endpackage

>>> design/brcm_if.sv
interface brcm_sample_if
    import brcm_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] corner_lo_lo;
    logic signed [VALUE_WIDTH-1:0] corner_lo_hi;
    logic signed [VALUE_WIDTH-1:0] corner_hi_lo;
    logic signed [VALUE_WIDTH-1:0] corner_hi_hi;
    logic        [FRAC_BITS:0]     frac_x;
    logic        [FRAC_BITS:0]     frac_y;

    modport source (
        output valid, corner_lo_lo, corner_lo_hi, corner_hi_lo, corner_hi_hi, frac_x, frac_y,
        input  ready
    );
    modport sink (
        input  valid, corner_lo_lo, corner_lo_hi, corner_hi_lo, corner_hi_hi, frac_x, frac_y,
        output ready
    );
endinterface

interface brcm_color_if
    import brcm_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] interp_value;
    logic        [COLOR_W-1:0]     red;
    logic        [COLOR_W-1:0]     green;
    logic        [COLOR_W-1:0]     blue;

    modport source (
        output valid, interp_value, red, green, blue,
        input  ready
    );
    modport sink (
        input  valid, interp_value, red, green, blue,
        output ready
    );
endinterface

>>> design/bilinear_rainbow_colormap_core.sv
// An accepted sample beat moves through register stages 0 to 7 to its color beat.
// Throughput: one beat per cycle while color.ready is high; each of the 8 register
// stages holds its own beat and empty stages close up while the output is stalled.
// Reset (rst_n low, asynchronous): all stages empty, min_value = 0,
// band_width = 1.0, band_scale = 256.0.
module bilinear_rainbow_colormap_core
    import brcm_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    localparam int STRIDE_LG  = (VALUE_WIDTH > 32) ? 3 : 2,
    localparam int ADDR_W     = STRIDE_LG + REG_IDX_W,
    localparam int PDATA_W    = (VALUE_WIDTH > 32) ? 64 : 32
) (
    input  logic               clk,
    input  logic               rst_n,
    brcm_sample_if.sink        sample,
    brcm_color_if.source       color,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int VW      = VALUE_WIDTH;
    localparam int FB      = FRAC_BITS;
    localparam int FW      = FB + 1;
    localparam int PROD_W  = VW + FB + 2;
    localparam int SUM_W   = PROD_W + 1;
    localparam int TW      = VW + 2;
    localparam int DW      = VW + 3;
    localparam int SCALE_W = (FB + 9 > SCALE_CFG_W) ? FB + 9 : SCALE_CFG_W;
    localparam int RP_W    = (VW + SCALE_W > 2 * FB + 9) ? VW + SCALE_W : 2 * FB + 9;
    localparam int RAMP_W  = FB + RAMP_INT;
    localparam int R76_W   = RAMP_W + 7;
    localparam int NST     = 8;

    localparam logic [FW-1:0]      ONE   = FW'(1) << FB;
    localparam logic [SUM_W-1:0]   HALF  = SUM_W'(1) << (FB - 1);
    localparam logic [VW-2:0]      BW_RST = (VW - 1)'(1) << FB;
    localparam logic [SCALE_W-1:0] SC_RST = SCALE_W'(256) << FB;

    // ---------------- configuration ----------------
    logic [VW-1:0]          min_value_reg;
    logic [VW-2:0]          band_width_reg;
    logic [SCALE_W-1:0]     band_scale_reg;
    logic signed [TW-1:0]   t0_reg, t1_reg, t2_reg, t3_reg;
    logic signed [TW-1:0]   t0_next, t1_next, t2_next, t3_next;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:STRIDE_LG];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_value_reg  <= '0;
            band_width_reg <= BW_RST;
            band_scale_reg <= SC_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_MIN_VALUE:  min_value_reg  <= pwdata[VW-1:0];
                REG_BAND_WIDTH: band_width_reg <= pwdata[VW-2:0];
                REG_BAND_SCALE: band_scale_reg <= SCALE_W'(pwdata[SCALE_CFG_W-1:0]);
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MIN_VALUE:  prdata = PDATA_W'(min_value_reg);
            REG_BAND_WIDTH: prdata = PDATA_W'(band_width_reg);
            REG_BAND_SCALE: prdata = PDATA_W'(band_scale_reg[SCALE_CFG_W-1:0]);
            default:        prdata = '0;
        endcase
    end

    // band thresholds, refreshed every cycle from the registers
    always_comb
    begin
        t0_next = TW'($signed(min_value_reg));
        t1_next = t0_next + $signed(TW'(band_width_reg));
        t2_next = t0_next + $signed(TW'({band_width_reg, 1'b0}));
        t3_next = t1_next + $signed(TW'({band_width_reg, 1'b0}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_reg <= '0;
            t1_reg <= TW'(BW_RST);
            t2_reg <= TW'({BW_RST, 1'b0});
            t3_reg <= TW'(BW_RST) + TW'({BW_RST, 1'b0});
        end
        else
        begin
            t0_reg <= t0_next;
            t1_reg <= t1_next;
            t2_reg <= t2_next;
            t3_reg <= t3_next;
        end
    end

    // ---------------- pipeline control ----------------
    logic [NST-1:0] vld_reg;
    logic [NST:0]   en;

    always_comb
    begin
        en[NST] = color.ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= sample.valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign sample.ready = en[0];
    assign color.valid  = vld_reg[NST-1];

    function automatic logic signed [VW-1:0] round_q(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        t = s + HALF;
        return t[FB+VW-1:FB];
    endfunction

    // ---------------- stage 0: x weights, row products ----------------
    logic [FW-1:0]             fx_c, wx, fy_c;
    logic signed [PROD_W-1:0]  p0_next, p1_next, p2_next, p3_next;
    logic signed [PROD_W-1:0]  p0_reg, p1_reg, p2_reg, p3_reg;
    logic [FW-1:0]             fy0_reg;

    assign fx_c = (sample.frac_x > ONE) ? ONE : sample.frac_x;
    assign fy_c = (sample.frac_y > ONE) ? ONE : sample.frac_y;
    assign wx   = ONE - fx_c;

    assign p0_next = PROD_W'(sample.corner_lo_lo) * PROD_W'($signed({1'b0, wx}));
    assign p1_next = PROD_W'(sample.corner_lo_hi) * PROD_W'($signed({1'b0, fx_c}));
    assign p2_next = PROD_W'(sample.corner_hi_lo) * PROD_W'($signed({1'b0, wx}));
    assign p3_next = PROD_W'(sample.corner_hi_hi) * PROD_W'($signed({1'b0, fx_c}));

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p0_reg  <= p0_next;
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            p3_reg  <= p3_next;
            fy0_reg <= fy_c;
        end
    end

    // ---------------- stage 1: row values ----------------
    logic signed [VW-1:0] row0_reg, row1_reg;
    logic [FW-1:0]        fy1_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            row0_reg <= round_q(SUM_W'(p0_reg) + SUM_W'(p1_reg));
            row1_reg <= round_q(SUM_W'(p2_reg) + SUM_W'(p3_reg));
            fy1_reg  <= fy0_reg;
        end
    end

    // ---------------- stage 2: column products ----------------
    logic signed [PROD_W-1:0] q0_reg, q1_reg;
    logic [FW-1:0]            wy;

    assign wy = ONE - fy1_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            q0_reg <= PROD_W'(row0_reg) * PROD_W'($signed({1'b0, wy}));
            q1_reg <= PROD_W'(row1_reg) * PROD_W'($signed({1'b0, fy1_reg}));
        end
    end

    // ---------------- stage 3: interpolated value ----------------
    logic signed [VW-1:0] v3_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            v3_reg <= round_q(SUM_W'(q0_reg) + SUM_W'(q1_reg));
        end
    end

    // ---------------- stage 4: band select, offset ----------------
    logic signed [DW-1:0] d0, d1, d2, d3;
    logic                 pos0, pos1, pos2, pos3;
    band_t                band_next, band4_reg;
    logic [VW-1:0]        off_next, off_reg;
    logic signed [VW-1:0] v4_reg;

    assign d0 = DW'(v3_reg) - DW'(t0_reg);
    assign d1 = DW'(v3_reg) - DW'(t1_reg);
    assign d2 = DW'(v3_reg) - DW'(t2_reg);
    assign d3 = DW'(v3_reg) - DW'(t3_reg);
    assign pos0 = !d0[DW-1] && (d0 != '0);
    assign pos1 = !d1[DW-1] && (d1 != '0);
    assign pos2 = !d2[DW-1] && (d2 != '0);
    assign pos3 = !d3[DW-1] && (d3 != '0);

    always_comb
    begin
        if (pos3)
        begin
            band_next = BAND_TOP;
            off_next  = d3[VW-1:0];
        end
        else if (pos2)
        begin
            band_next = BAND_UPPER;
            off_next  = d2[VW-1:0];
        end
        else if (pos1)
        begin
            band_next = BAND_LOWER;
            off_next  = d1[VW-1:0];
        end
        else
        begin
            band_next = BAND_BASE;
            off_next  = pos0 ? d0[VW-1:0] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            band4_reg <= band_next;
            off_reg   <= off_next;
            v4_reg    <= v3_reg;
        end
    end

    // ---------------- stage 5: ramp product ----------------
    logic [RP_W-1:0]      rp_reg;
    band_t                band5_reg;
    logic signed [VW-1:0] v5_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            rp_reg    <= RP_W'(off_reg) * RP_W'(band_scale_reg);
            band5_reg <= band4_reg;
            v5_reg    <= v4_reg;
        end
    end

    // ---------------- stage 6: clamp, ramp index ----------------
    logic                  rp_sat;
    logic [RAMP_W-1:0]     ramp;
    logic [R76_W-1:0]      ramp76;
    logic [COLOR_W-1:0]    idx_reg;
    logic [QUOT_IN_W-1:0]  x_reg;
    band_t                 band6_reg;
    logic signed [VW-1:0]  v6_reg;

    assign rp_sat = |rp_reg[RP_W-1:2*FB+RAMP_INT];
    assign ramp   = rp_sat ? '1 : rp_reg[2*FB+RAMP_INT-1:FB];
    assign ramp76 = R76_W'(ramp) * R76_W'(LOW_END);

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            idx_reg   <= ramp[RAMP_W-1:FB];
            x_reg     <= ramp76[FB+QUOT_IN_W-1:FB];
            band6_reg <= band5_reg;
            v6_reg    <= v5_reg;
        end
    end

    // ---------------- stage 7: color, dimming ----------------
    logic [COLOR_W-1:0]   low_tmp;
    logic [COLOR_W-1:0]   r_c, g_c, b_c;
    logic [COLOR_W-1:0]   red_reg, green_reg, blue_reg;
    logic signed [VW-1:0] v7_reg;

    assign low_tmp = LOW_END - div255(x_reg);

    always_comb
    begin
        case (band6_reg)
            BAND_TOP:
            begin
                r_c = CH_MAX;
                g_c = CH_MAX - idx_reg;
                b_c = CH_ZERO;
            end
            BAND_UPPER:
            begin
                r_c = idx_reg;
                g_c = CH_MAX;
                b_c = CH_ZERO;
            end
            BAND_LOWER:
            begin
                r_c = CH_ZERO;
                g_c = idx_reg;
                b_c = CH_MAX - idx_reg;
            end
            default:
            begin
                r_c = low_tmp;
                g_c = CH_ZERO;
                b_c = CH_MAX - low_tmp;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            red_reg   <= dim(r_c);
            green_reg <= dim(g_c);
            blue_reg  <= dim(b_c);
            v7_reg    <= v6_reg;
        end
    end

    assign color.interp_value = v7_reg;
    assign color.red          = red_reg;
    assign color.green        = green_reg;
    assign color.blue         = blue_reg;

    // ---------------- assertions ----------------
    a_dim_floor: assert property (@(posedge clk) disable iff (!rst_n)
        color.valid |-> (color.red >= DIM_OFFSET && color.green >= DIM_OFFSET &&
                         color.blue >= DIM_OFFSET))
        else $error("color channel below dim floor");

    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |-> !((&vld_reg) && !color.ready))
        else $error("beat accepted into a full stalled pipeline");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[4] && !en[4]) |=> ($stable(off_reg) && $stable(band4_reg) &&
                                    $stable(v4_reg)))
        else $error("held stage changed during stall");

    a_thresh_order: assert property (@(posedge clk) disable iff (!rst_n)
        (t0_reg <= t1_reg) && (t1_reg <= t2_reg) && (t2_reg <= t3_reg))
        else $error("band thresholds out of order");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import brcm_pkg::*;

    localparam int VW             = VALUE_WIDTH_DEF;
    localparam int FB             = FRAC_BITS_DEF;
    localparam int ADDR_W         = 4;
    localparam int REG_STRIDE     = 4;
    localparam int PIPE_LATENCY   = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_OFF       = 300;
    localparam int PHASE_BEATS    = 175;
    localparam int REPORT_MAX     = 10;
    localparam longint ONE_Q      = longint'(1) << FB;
    localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

    typedef struct {
        logic signed [VW-1:0] corner_lo_lo, corner_lo_hi, corner_hi_lo, corner_hi_hi;
        logic        [FB:0]   frac_x, frac_y;
    } sample_beat_t;

    typedef struct {
        logic signed [VW-1:0]      interp_value;
        logic        [COLOR_W-1:0] red, green, blue;
    } color_beat_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    brcm_sample_if sample_bus ();
    brcm_color_if  color_bus ();

    bilinear_rainbow_colormap_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_bus),
        .color   (color_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the register file
    logic signed [VW-1:0]          cfg_min;
    logic        [VW-2:0]          cfg_band;
    logic        [SCALE_CFG_W-1:0] cfg_scale;

    color_beat_t  pending_colors[$];
    color_beat_t  want_color;
    stall_mode_t  stall_mode;
    bit           gaps_on;
    int           burst_left;
    int           hold_cycles;
    int           pattern_cnt;
    int           idle_cycles;
    int           mismatches;
    int           samples_sent;
    int           colors_seen;
    int           settings_used;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint lerp_q(longint a, longint b, longint f);
        longint acc;
        acc = a * (ONE_Q - f) + b * f;
        return (acc + (ONE_Q >>> 1)) >>> FB;
    endfunction

    // ramp position with FB fraction bits, clamped below 256.0
    function automatic longint ramp_q(longint off);
        logic [95:0] prod;
        if (off <= 0)
            return 0;
        prod = 96'(off) * 96'(cfg_scale);
        if (prod[95:RAMP_INT+2*FB] != 0)
            return (longint'(1) << (RAMP_INT + FB)) - 1;
        return longint'(prod[RAMP_INT+2*FB-1:FB]);
    endfunction

    function automatic longint shade(longint c);
        return c * 3 / 4 + longint'(DIM_OFFSET);
    endfunction

    function automatic color_beat_t predict_color(sample_beat_t s);
        longint fx, fy, row_lo, row_hi, v, bw, t1, t2, t3, idx, r, g, b;
        color_beat_t c;
        fx = longint'(s.frac_x);
        fy = longint'(s.frac_y);
        if (fx > ONE_Q)
            fx = ONE_Q;
        if (fy > ONE_Q)
            fy = ONE_Q;
        row_lo = lerp_q(longint'(s.corner_lo_lo), longint'(s.corner_lo_hi), fx);
        row_hi = lerp_q(longint'(s.corner_hi_lo), longint'(s.corner_hi_hi), fx);
        v = lerp_q(row_lo, row_hi, fy);
        bw = longint'(cfg_band);
        t1 = longint'(cfg_min) + bw;
        t2 = t1 + bw;
        t3 = t2 + bw;
        if (v > t3)
        begin
            idx = ramp_q(v - t3) >>> FB;
            r = longint'(CH_MAX);
            g = longint'(CH_MAX) - idx;
            b = longint'(CH_ZERO);
        end
        else if (v > t2)
        begin
            idx = ramp_q(v - t2) >>> FB;
            r = idx;
            g = longint'(CH_MAX);
            b = longint'(CH_ZERO);
        end
        else if (v > t1)
        begin
            idx = ramp_q(v - t1) >>> FB;
            r = longint'(CH_ZERO);
            g = idx;
            b = longint'(CH_MAX) - idx;
        end
        else
        begin
            r = longint'(LOW_END) - (ramp_q(v - longint'(cfg_min)) * longint'(LOW_END))
                / (longint'(CH_MAX) << FB);
            g = longint'(CH_ZERO);
            b = longint'(CH_MAX) - r;
        end
        c.interp_value = VW'(v);
        c.red   = COLOR_W'(shade(r));
        c.green = COLOR_W'(shade(g));
        c.blue  = COLOR_W'(shade(b));
        return c;
    endfunction

    function automatic logic signed [VW-1:0] sat_val(longint x);
        if (x > longint'(VAL_MAX))
            return VAL_MAX;
        if (x < longint'(VAL_MIN))
            return VAL_MIN;
        return VW'(x);
    endfunction

    function automatic sample_beat_t mk(logic signed [VW-1:0] a, logic signed [VW-1:0] b,
                                        logic signed [VW-1:0] c, logic signed [VW-1:0] d,
                                        logic [FB:0] fx, logic [FB:0] fy);
        sample_beat_t s;
        s.corner_lo_lo = a;
        s.corner_lo_hi = b;
        s.corner_hi_lo = c;
        s.corner_hi_hi = d;
        s.frac_x = fx;
        s.frac_y = fy;
        return s;
    endfunction

    // equal corners: the value comes out exact whatever the fractions
    function automatic sample_beat_t flat(longint v);
        logic signed [VW-1:0] x;
        x = sat_val(v);
        return mk(x, x, x, x, (FB+1)'($urandom), (FB+1)'($urandom));
    endfunction

    function automatic logic [FB:0] rand_frac();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return (FB+1)'(ONE_Q);
            2: return (FB+1)'($urandom);
            default: return (FB+1)'($urandom_range(0, int'(ONE_Q)));
        endcase
    endfunction

    function automatic logic signed [VW-1:0] near_band();
        longint bw, span, off;
        bw = longint'(cfg_band);
        span = 5 * bw + 8;
        off = longint'({$urandom, $urandom} >> 1) % span;
        return sat_val(longint'(cfg_min) - bw - 4 + off);
    endfunction

    function automatic logic signed [VW-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            3: return '1;
            default: return cfg_min;
        endcase
    endfunction

    function automatic sample_beat_t rand_sample();
        sample_beat_t s;
        logic signed [VW-1:0] v;
        case ($urandom_range(0, 9))
            0, 1: s = mk($urandom, $urandom, $urandom, $urandom, rand_frac(), rand_frac());
            8: s = mk(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                      rand_frac(), rand_frac());
            9:
            begin
                // right on a band threshold or one LSB either side
                v = sat_val(longint'(cfg_min) + longint'($urandom_range(0, 3))
                            * longint'(cfg_band) + longint'($urandom_range(0, 2)) - 1);
                s = mk(v, v, v, v, rand_frac(), rand_frac());
            end
            default: s = mk(near_band(), near_band(), near_band(), near_band(),
                            rand_frac(), rand_frac());
        endcase
        return s;
    endfunction

    task automatic push_sample(input sample_beat_t s);
        sample_bus.valid        <= 1'b1;
        sample_bus.corner_lo_lo <= s.corner_lo_lo;
        sample_bus.corner_lo_hi <= s.corner_lo_hi;
        sample_bus.corner_hi_lo <= s.corner_hi_lo;
        sample_bus.corner_hi_hi <= s.corner_hi_hi;
        sample_bus.frac_x       <= s.frac_x;
        sample_bus.frac_y       <= s.frac_y;
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
        pending_colors = {pending_colors, predict_color(s)};
        samples_sent++;
    endtask

    task automatic run_random(input int n);
        int i;
        for (i = 0; i < n; i++)
        begin
            if (gaps_on && burst_left == 0)
            begin
                sample_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
            push_sample(rand_sample());
            if (burst_left > 0)
                burst_left--;
        end
    endtask

    // stop sending and let every outstanding color beat drain
    task automatic settle();
        sample_bus.valid <= 1'b0;
        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * REG_STRIDE);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_VALUE:  cfg_min   = data;
            REG_BAND_WIDTH: cfg_band  = data[VW-2:0];
            REG_BAND_SCALE: cfg_scale = data;
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [31:0] min_v, input logic [31:0] band_v,
                                input logic [31:0] scale_v);
        settle();
        cfg_write(REG_MIN_VALUE, min_v);
        cfg_write(REG_BAND_WIDTH, band_v);
        cfg_write(REG_BAND_SCALE, scale_v);
        settings_used++;
    endtask

    task automatic test_band_edges();
        stall_mode = STALL_PATTERN;
        push_sample(flat(0));
        push_sample(flat(ONE_Q));
        push_sample(flat(2 * ONE_Q));
        push_sample(flat(3 * ONE_Q));
        push_sample(flat(4 * ONE_Q));
        push_sample(flat(ONE_Q + 1));
        push_sample(flat(2 * ONE_Q + 1));
        push_sample(flat(3 * ONE_Q + 1));
        push_sample(flat(ONE_Q / 2));
        push_sample(flat(3 * ONE_Q + ONE_Q / 2));
        push_sample(flat(-1));
        push_sample(flat(longint'(VAL_MAX)));
        push_sample(flat(longint'(VAL_MIN)));
    endtask

    task automatic test_interpolation();
        stall_mode = STALL_RANDOM;
        // half-way ties round up
        push_sample(mk(0, 1, 0, 1, 17'h08000, 17'h00000));
        push_sample(mk(0, -1, 0, -1, 17'h08000, 17'h00000));
        push_sample(mk(VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, 17'h08000, 17'h08000));
        // corner selection and fraction clamp above 1.0
        push_sample(mk(32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 17'h10000, 17'h00000));
        push_sample(mk(32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 17'h00000, 17'h10000));
        push_sample(mk(32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 17'h10000, 17'h10000));
        push_sample(mk(32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 17'h1FFFF, 17'h1FFFF));
        push_sample(mk(32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 17'h10001, 17'h00000));
        push_sample(mk(32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 17'h00000, 17'h10001));
        push_sample(mk(32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 17'h00001, 17'h00001));
        push_sample(mk(VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX, 17'h00000, 17'h00001));
    endtask

    task automatic test_zero_band();
        stall_mode = STALL_RANDOM;
        apply_config(32'h0000_1000, 32'h0, 32'h0);
        push_sample(flat(longint'(cfg_min) - 1));
        push_sample(flat(longint'(cfg_min)));
        push_sample(flat(longint'(cfg_min) + 1));
        push_sample(flat(longint'(VAL_MAX)));
        apply_config(32'h0000_1000, 32'h0, 32'h0100_0000);
        push_sample(flat(longint'(cfg_min)));
        push_sample(flat(longint'(cfg_min) + 1));
        push_sample(flat(longint'(VAL_MAX)));
        push_sample(flat(longint'(VAL_MIN)));
    endtask

    task automatic test_ramp_saturation();
        stall_mode = STALL_PATTERN;
        apply_config(VAL_MIN, 32'h0000_0001, 32'hFFFF_FFFF);
        push_sample(flat(longint'(VAL_MAX)));
        push_sample(flat(longint'(VAL_MIN)));
        push_sample(flat(longint'(VAL_MIN) + 1));
        push_sample(flat(longint'(VAL_MIN) + 2));
        push_sample(flat(longint'(VAL_MIN) + 3));
        push_sample(flat(longint'(VAL_MIN) + 4));
        // band_width written with bit 31 set, which the register drops
        apply_config(VAL_MAX, 32'hFFFF_FFFF, 32'h0);
        push_sample(flat(longint'(VAL_MAX)));
        push_sample(flat(longint'(VAL_MIN)));
        push_sample(flat(0));
    endtask

    task automatic test_backpressure();
        apply_config(32'h0, 32'h0001_0000, 32'h0100_0000);
        stall_mode = STALL_NONE;
        gaps_on = 1'b0;
        @(negedge clk);
        hold_cycles = HOLD_OFF;
        @(posedge clk);
        run_random(60);
        settle();
    endtask

    task automatic test_random_settings();
        longint bw, scale;
        apply_config(32'h0, 32'h0001_0000, 32'h0100_0000);
        stall_mode = STALL_RANDOM;
        gaps_on = 1'b1;
        run_random(PHASE_BEATS);

        apply_config(32'hFFFD_0000, 32'h0000_8000, 32'h0200_0000);
        stall_mode = STALL_PATTERN;
        run_random(PHASE_BEATS);

        apply_config(VAL_MIN, 32'h7FFF_FFFF, 32'h0000_0200);
        stall_mode = STALL_NONE;
        gaps_on = 1'b0;
        run_random(PHASE_BEATS);

        apply_config($urandom, 32'h0, 32'h0);
        stall_mode = STALL_RANDOM;
        gaps_on = 1'b1;
        run_random(PHASE_BEATS);

        apply_config(VAL_MAX, 32'd100, 32'hFFFF_FFFF);
        stall_mode = STALL_PATTERN;
        gaps_on = 1'b0;
        run_random(PHASE_BEATS);

        bw = longint'($urandom_range(1, 1 << 20));
        scale = (longint'(256) << (2 * FB)) / bw;
        if (scale > longint'(32'hFFFF_FFFF))
            scale = longint'(32'hFFFF_FFFF);
        apply_config(32'($signed($urandom_range(0, 1 << 25)) - (1 << 24)), 32'(bw),
                     32'(scale));
        stall_mode = STALL_RANDOM;
        gaps_on = 1'b1;
        run_random(PHASE_BEATS);
    endtask

    // color sink with its own stall pattern and a counted hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            color_bus.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            color_bus.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
        begin
            case (stall_mode)
                STALL_NONE:   color_bus.ready <= 1'b1;
                STALL_RANDOM: color_bus.ready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    color_bus.ready <= (pattern_cnt >= 4);
                    pattern_cnt <= (pattern_cnt + 1) % 11;
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && color_bus.valid && color_bus.ready)
        begin
            colors_seen++;
            if (pending_colors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected color beat: value %h rgb %h %h %h",
                             color_bus.interp_value, color_bus.red, color_bus.green,
                             color_bus.blue);
            end
            else
            begin
                want_color = pending_colors.pop_front();
                if (want_color.interp_value !== color_bus.interp_value ||
                    want_color.red !== color_bus.red || want_color.green !== color_bus.green ||
                    want_color.blue !== color_bus.blue)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch beat %0d: expected %h rgb %h %h %h, got %h rgb %h %h %h",
                                 colors_seen, want_color.interp_value, want_color.red,
                                 want_color.green, want_color.blue, color_bus.interp_value,
                                 color_bus.red, color_bus.green, color_bus.blue);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_bus.valid && sample_bus.ready) ||
            (color_bus.valid && color_bus.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles, %0d color beats outstanding",
                     idle_cycles, pending_colors.size());
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_bus.valid = 1'b0;
        sample_bus.corner_lo_lo = '0;
        sample_bus.corner_lo_hi = '0;
        sample_bus.corner_hi_lo = '0;
        sample_bus.corner_hi_hi = '0;
        sample_bus.frac_x = '0;
        sample_bus.frac_y = '0;
        color_bus.ready = 1'b0;
        cfg_min = '0;
        cfg_band = (VW-1)'(ONE_Q);
        cfg_scale = SCALE_CFG_W'(longint'(256) << FB);
        stall_mode = STALL_NONE;
        gaps_on = 1'b0;
        burst_left = 0;
        hold_cycles = 0;
        pattern_cnt = 0;
        idle_cycles = 0;
        mismatches = 0;
        samples_sent = 0;
        colors_seen = 0;
        settings_used = 1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_band_edges();
        test_interpolation();
        test_zero_band();
        test_ramp_saturation();
        test_backpressure();
        test_random_settings();

        settle();
        $display("Run covered %0d samples and %0d color beats over %0d register settings.",
                 samples_sent, colors_seen, settings_used);
        $display("Included band edges, rounding ties, fraction clamp, zero band, ramp clamp, stalls.");
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
